// ----- src/yscb_pkg.sv -----
// Package for the YUV-space colour blend: widths, fixed-point coefficients,
// error codes, payload structs and the rounding helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package yscb_pkg;

    localparam int COEF_FRAC_BITS   = 12;
    localparam int FACTOR_FRAC_BITS = 8;

    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int FAC_W = 9;
    localparam int ERR_W = 2;

    // Pipeline depth: three stages for the RGB to YUV conversion, six after it.
    localparam int YUV_STAGES = 3;
    localparam int NST        = 9;

    // Coefficient, YUV and product widths, all derived from the fraction bits.
    localparam int KW     = COEF_FRAC_BITS + 3;
    localparam int YUV_W  = COEF_FRAC_BITS + 10;
    localparam int DIF_W  = YUV_W + 1;
    localparam int UVP_W  = DIF_W + KW;
    localparam int BLP_W  = DIF_W + FAC_W + 1;
    localparam int MCP_W  = YUV_W + KW;
    localparam int CHF_W  = YUV_W + 1;
    localparam int INT_W  = CHF_W - COEF_FRAC_BITS + 1;

    localparam int FAC_ONE = 1 << FACTOR_FRAC_BITS;
    localparam int CH_MAX  = (1 << CH_W) - 1;

    localparam logic signed [KW-1:0] K_YR = KW'((299  * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_YG = KW'((587  * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_YB = KW'((114  * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_U  = KW'((492  * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_V  = KW'((877  * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_RV = KW'((1140 * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_GU = KW'((395  * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_GV = KW'((581  * (2 ** COEF_FRAC_BITS) + 500) / 1000);
    localparam logic signed [KW-1:0] K_BU = KW'((2032 * (2 ** COEF_FRAC_BITS) + 500) / 1000);

    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FACTOR = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE  = 2'd2;

    typedef struct packed {
        logic signed [YUV_W-1:0] y;
        logic signed [YUV_W-1:0] u;
        logic signed [YUV_W-1:0] v;
    } t_yuv;

    typedef struct packed {
        logic signed [DIF_W-1:0] y;
        logic signed [DIF_W-1:0] u;
        logic signed [DIF_W-1:0] v;
    } t_yuv_dif;

    typedef struct packed {
        logic signed [BLP_W-1:0] y;
        logic signed [BLP_W-1:0] u;
        logic signed [BLP_W-1:0] v;
    } t_yuv_prod;

    // Divide by 2^s and round to nearest, ties away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] value,
                                                      input int s);
        logic signed [63:0] mag;
        logic signed [63:0] q;
        mag = (value < 0) ? -value : value;
        q   = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (value < 0) ? -q : q;
    endfunction

endpackage

`default_nettype wire

// ----- src/yscb_if.sv -----
// Stream interfaces for the colour blend: the input pixel pair with its factor,
// and the blended result. Depends on yscb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface yscb_in_if import yscb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] source_rgb;
    logic [PIX_W-1:0] target_rgb;
    logic [FAC_W-1:0] blend_factor;

    modport source(output valid, source_rgb, target_rgb, blend_factor, input ready);
    modport sink(input valid, source_rgb, target_rgb, blend_factor, output ready);
endinterface

interface yscb_out_if import yscb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] blended_rgb;
    logic [ERR_W-1:0] error_code;

    modport source(output valid, blended_rgb, error_code, input ready);
    modport sink(input valid, blended_rgb, error_code, output ready);
endinterface

`default_nettype wire

// ----- src/yscb_to_yuv.sv -----
// Three-stage RGB to YUV converter for one packed pixel, advanced by per-stage
// enables from the caller. Depends on yscb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yscb_to_yuv import yscb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic [YUV_STAGES-1:0] i_en,
    input  wire logic [PIX_W-1:0]      i_rgb,
    output t_yuv                       o_yuv
);

    logic [CH_W-1:0]         w_r;
    logic [CH_W-1:0]         w_g;
    logic [CH_W-1:0]         w_b;
    logic signed [YUV_W-1:0] n_y;
    logic signed [YUV_W-1:0] r_y0;
    logic [CH_W-1:0]         r_r0;
    logic [CH_W-1:0]         r_b0;
    logic signed [DIF_W-1:0] w_du;
    logic signed [DIF_W-1:0] w_dv;
    logic signed [UVP_W-1:0] n_pu;
    logic signed [UVP_W-1:0] n_pv;
    logic signed [UVP_W-1:0] r_pu;
    logic signed [UVP_W-1:0] r_pv;
    logic signed [YUV_W-1:0] r_y1;
    t_yuv                    r_yuv;

    assign w_r = i_rgb[3*CH_W-1:2*CH_W];
    assign w_g = i_rgb[2*CH_W-1:CH_W];
    assign w_b = i_rgb[CH_W-1:0];

    assign n_y = YUV_W'($signed({1'b0, w_r}) * K_YR + $signed({1'b0, w_g}) * K_YG
                      + $signed({1'b0, w_b}) * K_YB);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_y0 <= n_y;
            r_r0 <= w_r;
            r_b0 <= w_b;
        end
    end

    assign w_du = $signed(DIF_W'({r_b0, {COEF_FRAC_BITS{1'b0}}})) - DIF_W'(r_y0);
    assign w_dv = $signed(DIF_W'({r_r0, {COEF_FRAC_BITS{1'b0}}})) - DIF_W'(r_y0);
    assign n_pu = UVP_W'(w_du) * UVP_W'(K_U);
    assign n_pv = UVP_W'(w_dv) * UVP_W'(K_V);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pu <= n_pu;
            r_pv <= n_pv;
            r_y1 <= r_y0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_yuv.y <= r_y1;
            r_yuv.u <= YUV_W'(round_shift(64'(r_pu), COEF_FRAC_BITS));
            r_yuv.v <= YUV_W'(round_shift(64'(r_pv), COEF_FRAC_BITS));
        end
    end

    assign o_yuv = r_yuv;

endmodule

`default_nettype wire

// ----- src/yuv_space_color_blend.sv -----
// Top level of the YUV-space colour blend: converts two pixels to YUV,
// interpolates, converts back and rounds. Depends on yscb_pkg, yscb_if and
// yscb_to_yuv.
//
//  Port     Direction  Carries
//  i_pix    sink       source_rgb, target_rgb, blend_factor
//  o_pix    source     blended_rgb, error_code
//
// Each word passes through nine stages in all. One word can enter in every
// cycle unless all stages are full and the output is stalled; each stage
// moves on when it is empty or the stage after it moves, so bubbles are
// squeezed out during a stall.
// A stalled output holds its word while upstream stages keep filling.
// Reset (synchronous, active low) clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module yuv_space_color_blend import yscb_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    yscb_in_if.sink    i_pix,
    yscb_out_if.source o_pix
);

    logic [NST-1:0]          r_vld;
    logic [NST-1:0]          w_en;
    logic [FAC_W-1:0]        r_fac [0:3];
    logic                    r_err [0:NST-2];
    t_yuv                    w_yuv_a;
    t_yuv                    w_yuv_b;

    t_yuv                    r_a3;
    t_yuv_dif                r_d3;
    t_yuv                    r_a4;
    t_yuv_prod               r_p4;
    t_yuv                    r_m5;
    logic signed [YUV_W-1:0] r_my6;
    logic signed [MCP_W-1:0] r_qrv6;
    logic signed [MCP_W-1:0] r_qgu6;
    logic signed [MCP_W-1:0] r_qgv6;
    logic signed [MCP_W-1:0] r_qbu6;
    logic signed [CHF_W-1:0] r_cr7;
    logic signed [CHF_W-1:0] r_cg7;
    logic signed [CHF_W-1:0] r_cb7;
    logic [PIX_W-1:0]        r_rgb;
    logic [ERR_W-1:0]        r_code;

    logic signed [BLP_W-1:0] w_fac_s;
    logic signed [INT_W-1:0] w_nr;
    logic signed [INT_W-1:0] w_ng;
    logic signed [INT_W-1:0] w_nb;
    logic [INT_W-1:0]        w_ar;
    logic [INT_W-1:0]        w_ag;
    logic [INT_W-1:0]        w_ab;
    logic                    w_range;

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || o_pix.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_pix.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Side band: factor and factor error travel beside the data.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_fac[0] <= i_pix.blend_factor;
            r_err[0] <= (32'(i_pix.blend_factor) > FAC_ONE);
        end
        for (int k = 1; k < 4; k++) begin
            if (w_en[k]) begin
                r_fac[k] <= r_fac[k-1];
            end
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (w_en[k]) begin
                r_err[k] <= r_err[k-1];
            end
        end
    end

    yscb_to_yuv u_yuv_a (
        .i_clk (i_clk),
        .i_en  (w_en[YUV_STAGES-1:0]),
        .i_rgb (i_pix.source_rgb),
        .o_yuv (w_yuv_a)
    );

    yscb_to_yuv u_yuv_b (
        .i_clk (i_clk),
        .i_en  (w_en[YUV_STAGES-1:0]),
        .i_rgb (i_pix.target_rgb),
        .o_yuv (w_yuv_b)
    );

    // Target minus source in YUV.
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_a3   <= w_yuv_a;
            r_d3.y <= DIF_W'(w_yuv_b.y) - DIF_W'(w_yuv_a.y);
            r_d3.u <= DIF_W'(w_yuv_b.u) - DIF_W'(w_yuv_a.u);
            r_d3.v <= DIF_W'(w_yuv_b.v) - DIF_W'(w_yuv_a.v);
        end
    end

    assign w_fac_s = $signed(BLP_W'(r_fac[3]));

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_a4   <= r_a3;
            r_p4.y <= BLP_W'(r_d3.y) * w_fac_s;
            r_p4.u <= BLP_W'(r_d3.u) * w_fac_s;
            r_p4.v <= BLP_W'(r_d3.v) * w_fac_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_m5.y <= YUV_W'(64'(r_a4.y) + round_shift(64'(r_p4.y), FACTOR_FRAC_BITS));
            r_m5.u <= YUV_W'(64'(r_a4.u) + round_shift(64'(r_p4.u), FACTOR_FRAC_BITS));
            r_m5.v <= YUV_W'(64'(r_a4.v) + round_shift(64'(r_p4.v), FACTOR_FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_my6  <= r_m5.y;
            r_qrv6 <= MCP_W'(r_m5.v) * MCP_W'(K_RV);
            r_qgu6 <= MCP_W'(r_m5.u) * MCP_W'(K_GU);
            r_qgv6 <= MCP_W'(r_m5.v) * MCP_W'(K_GV);
            r_qbu6 <= MCP_W'(r_m5.u) * MCP_W'(K_BU);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_cr7 <= CHF_W'(64'(r_my6) + round_shift(64'(r_qrv6), COEF_FRAC_BITS));
            r_cg7 <= CHF_W'(64'(r_my6) - round_shift(64'(r_qgu6), COEF_FRAC_BITS)
                            - round_shift(64'(r_qgv6), COEF_FRAC_BITS));
            r_cb7 <= CHF_W'(64'(r_my6) + round_shift(64'(r_qbu6), COEF_FRAC_BITS));
        end
    end

    // Round each channel to an integer, fold negatives and range-check.
    assign w_nr = INT_W'(round_shift(64'(r_cr7), COEF_FRAC_BITS));
    assign w_ng = INT_W'(round_shift(64'(r_cg7), COEF_FRAC_BITS));
    assign w_nb = INT_W'(round_shift(64'(r_cb7), COEF_FRAC_BITS));
    assign w_ar = (w_nr < 0) ? INT_W'(-w_nr) : INT_W'(w_nr);
    assign w_ag = (w_ng < 0) ? INT_W'(-w_ng) : INT_W'(w_ng);
    assign w_ab = (w_nb < 0) ? INT_W'(-w_nb) : INT_W'(w_nb);
    assign w_range = (w_ar > INT_W'(CH_MAX)) || (w_ag > INT_W'(CH_MAX))
                  || (w_ab > INT_W'(CH_MAX));

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            if (r_err[NST-2]) begin
                r_rgb  <= '0;
                r_code <= ERR_FACTOR;
            end else if (w_range) begin
                r_rgb  <= '0;
                r_code <= ERR_RANGE;
            end else begin
                r_rgb  <= {w_ar[CH_W-1:0], w_ag[CH_W-1:0], w_ab[CH_W-1:0]};
                r_code <= ERR_NONE;
            end
        end
    end

    assign o_pix.valid       = r_vld[NST-1];
    assign o_pix.blended_rgb = r_rgb;
    assign o_pix.error_code  = r_code;

    a_err_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && (o_pix.error_code != ERR_NONE) |-> (o_pix.blended_rgb == '0))
        else $error("error word carries a non-zero pixel");

    a_ready_when_tail_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NST-1] |-> i_pix.ready)
        else $error("input stalled with an empty output stage");

    a_accept_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    a_factor_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST-2] && r_err[NST-2] && w_en[NST-1] |=> (o_pix.error_code == ERR_FACTOR))
        else $error("factor error lost on the way to the output");

endmodule

`default_nettype wire
